/* rtl/tar_pkg.sv */
`default_nettype none
// ============================================================================
// tar_pkg - shared types and constants for the torus ASCII renderer
// Fixed-point formats, shade character set, quarter-wave sine table and the
// work word passed from the front end to the back end.
// ============================================================================
package tar_pkg;

    // number formats
    localparam int FRAC_BITS  = 14;
    localparam int ANGLE_BITS = 10;
    localparam int QTR_BITS   = ANGLE_BITS - 2;
    localparam int QTR_SIZE   = 1 << QTR_BITS;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int TRIG_W     = FRAC_BITS + 2;
    localparam int OP_W       = 24;
    localparam int VAL_W      = 32;
    localparam int CELL_W     = 11;
    localparam int ADDR_W     = 15;
    localparam int DEPTH_W    = 16;
    localparam int SHADE_W    = 4;
    localparam int CHAR_W     = 7;

    // divider: quotient of 2^(F+15) by the denominator
    localparam int DIV_N      = FRAC_BITS + 16;
    localparam int DEN_W      = 19;
    localparam int Q_W        = 17;
    localparam int DEPTH_MAX  = 65535;

    // projection and shading constants
    localparam int X_CENTER    = 40;
    localparam int Y_CENTER    = 12;
    localparam int X_SCALE     = 30;
    localparam int Y_SCALE     = 15;
    localparam int VIEW_DIST   = 5;
    localparam int TUBE_OFFSET = 2;
    localparam int LUM_SCALE   = 8;
    localparam int SHADE_LEVELS = 12;
    localparam int SHADE_MAX   = SHADE_LEVELS - 1;

    localparam logic [SHADE_W-1:0] BLANK_SHADE = SHADE_W'(SHADE_LEVELS);
    localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 7'h0A;
    localparam logic [CHAR_W-1:0]  CH_SPACE    = 7'h20;
    localparam logic [CHAR_W-1:0]  CH_NONE     = 7'h00;

    typedef logic [CHAR_W-1:0] shade_chars_t [SHADE_LEVELS];
    // ". , - ~ : ; = ! * # $ @" from dim to bright
    localparam shade_chars_t SHADE_CHARS = '{
        7'h2E, 7'h2C, 7'h2D, 7'h7E, 7'h3A, 7'h3B,
        7'h3D, 7'h21, 7'h2A, 7'h23, 7'h24, 7'h40
    };

    // quarter-wave sine, Q(FRAC_BITS), entries 0..QTR_SIZE
    typedef logic [FRAC_BITS:0] sin_tab_t [QTR_SIZE+1];

    // 9th-order odd polynomial in Q30, floored products, then rounded
    function automatic sin_tab_t build_sin_tab();
        sin_tab_t tab;
        longint   u;
        longint   u2;
        longint   acc;
        longint   s;
        for (int k = 0; k <= QTR_SIZE; k++) begin
            u   = longint'(k) <<< (30 - QTR_BITS);
            u2  = (u * u) >>> 30;
            acc = 172272;
            acc = ((acc * u2) >>> 30) - 5026995;
            acc = ((acc * u2) >>> 30) + 85569306;
            acc = ((acc * u2) >>> 30) - 693598668;
            acc = ((acc * u2) >>> 30) + 1686629713;
            s   = (acc * u) >>> 30;
            if (s > (longint'(1) <<< 30))
                s = longint'(1) <<< 30;
            if (s < 0)
                s = 0;
            s = (s + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
            tab[k] = s[FRAC_BITS:0];
        end
        return tab;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

    // one work word from front end to back end
    typedef struct packed {
        logic                is_read;
        logic                hit;
        logic                col0;
        logic [ADDR_W-1:0]   addr;
        logic [DEPTH_W-1:0]  depth;
        logic [SHADE_W-1:0]  shade;
    } work_t;

endpackage
`default_nettype wire

/* rtl/tar_div.sv */
`default_nettype none
// ============================================================================
// tar_div - radix-2 restoring divider
// Computes 2^(F+15) / den, one quotient bit per cycle.
// ============================================================================
module tar_div (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire  [tar_pkg::DEN_W-1:0]   den,
    output logic                        done,
    output logic [tar_pkg::Q_W-1:0]     quo
);
    import tar_pkg::*;

    localparam int CNT_W = $clog2(DIV_N);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_N - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DIV_N-1:0] num_reg;
    logic [DIV_N-1:0] quo_reg;
    logic [DEN_W:0]   rem_sh;
    logic             take;

    // trial subtract
    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[DIV_N-1]};
        take     = rem_sh >= {1'b0, den_reg};
        rem_next = take ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= '0;
            num_reg <= {1'b1, {(DIV_N-1){1'b0}}};
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[DIV_N-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_N-2:0], take};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg[Q_W-1:0];

endmodule
`default_nettype wire

/* rtl/tar_front.sv */
`default_nettype none
// ============================================================================
// tar_front - item intake, rotation and projection
// For plot items looks up sin/cos, runs the fmul sequence on one shared
// multiplier, divides for depth; every item gets a back end work word.
// ============================================================================
module tar_front #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 22
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             item_valid,
    output logic                            item_stall,
    input  wire                             mode,
    input  wire  [tar_pkg::ANGLE_BITS-1:0]  ring_angle,
    input  wire  [tar_pkg::ANGLE_BITS-1:0]  tube_angle,
    input  wire  [tar_pkg::ANGLE_BITS-1:0]  rot_a,
    input  wire  [tar_pkg::ANGLE_BITS-1:0]  rot_b,
    input  wire  [tar_pkg::CELL_W-1:0]      cell_req,
    input  wire                             clearing,
    output logic                            push,
    output tar_pkg::work_t                  push_data,
    input  wire                             q_full
);
    import tar_pkg::*;

    localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
    // row of a cell by reciprocal multiply, for the column 0 check
    localparam int RSH  = CELL_W + $clog2(SCREEN_COLS);
    localparam int PW   = CELL_W + RSH + 2;
    localparam longint RMUL = ((longint'(1) <<< RSH) + SCREEN_COLS - 1) / SCREEN_COLS;

    // multiply steps, also product slots
    localparam logic [4:0] P_CH  = 5'd0;
    localparam logic [4:0] P_CHE = 5'd1;
    localparam logic [4:0] P_FG  = 5'd2;
    localparam logic [4:0] P_CHG = 5'd3;
    localparam logic [4:0] P_FE  = 5'd4;
    localparam logic [4:0] P_LH  = 5'd5;
    localparam logic [4:0] P_CD  = 5'd6;
    localparam logic [4:0] P_LD  = 5'd7;
    localparam logic [4:0] P_CDG = 5'd8;
    localparam logic [4:0] P_CDE = 5'd9;
    localparam logic [4:0] P_LHM = 5'd10;
    localparam logic [4:0] P_TN  = 5'd11;
    localparam logic [4:0] P_LHN = 5'd12;
    localparam logic [4:0] P_TM  = 5'd13;
    localparam logic [4:0] P_B1  = 5'd14;
    localparam logic [4:0] P_LDN = 5'd15;
    localparam logic [4:0] P_PX  = 5'd16;
    localparam logic [4:0] P_PY  = 5'd17;
    localparam int NPROD = 18;

    typedef enum logic [7:0] {
        F_IDLE   = 8'b0000_0001,
        F_LOOK   = 8'b0000_0010,
        F_MUL    = 8'b0000_0100,
        F_DSTART = 8'b0000_1000,
        F_DIV    = 8'b0001_0000,
        F_PROJ   = 8'b0010_0000,
        F_FIN    = 8'b0100_0000,
        F_PUSH   = 8'b1000_0000
    } fstate_t;

    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [VAL_W-1:0]  val_t;
    typedef logic signed [OP_W-1:0]   op_t;

    // signed sine of an angle code from the quarter-wave table
    function automatic trig_t trig(input logic [ANGLE_BITS-1:0] a);
        logic [QTR_BITS:0]  idx;
        logic [FRAC_BITS:0] mag;
        idx = a[QTR_BITS] ? ((QTR_BITS+1)'(QTR_SIZE) - {1'b0, a[QTR_BITS-1:0]})
                          : {1'b0, a[QTR_BITS-1:0]};
        mag = SIN_TAB[idx];
        return a[ANGLE_BITS-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    function automatic op_t ext_t(input trig_t v);
        return {{(OP_W-TRIG_W){v[TRIG_W-1]}}, v};
    endfunction

    function automatic op_t cut_v(input val_t v);
        return v[OP_W-1:0];
    endfunction

    fstate_t state_reg, state_next;
    logic [4:0] step_reg, step_next;

    logic                    is_read_reg;
    logic [ANGLE_BITS-1:0]   th_reg, ph_reg, ra_reg, rb_reg;
    logic [CELL_W-1:0]       cell_reg;
    trig_t                   c_reg, l_reg, f_reg, d_reg, e_reg, g_reg, n_reg, m_reg;
    val_t                    prod_reg [NPROD];
    logic [Q_W-1:0]          quo_reg;
    work_t                   work_reg, work_next;

    logic                    accept;
    logic                    div_start, div_done;
    logic [Q_W-1:0]          div_quo;
    logic [DEN_W-1:0]        den_val;
    val_t                    den_raw, h_val, t_val;
    op_t                     mul_a, mul_b;
    logic signed [2*OP_W-1:0] mul_full, mul_sh;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != F_IDLE) || clearing;
    assign div_start  = (state_reg == F_DSTART);
    assign push       = (state_reg == F_PUSH) && !q_full;
    assign push_data  = work_reg;

    // shared terms
    always_comb
    begin
        h_val   = val_t'(d_reg) + TUBE_OFFSET * ONE;
        t_val   = prod_reg[P_CHG] - prod_reg[P_FE];
        den_raw = prod_reg[P_CHE] + prod_reg[P_FG] + VIEW_DIST * ONE;
        if (den_raw < ONE / 2)
            den_val = DEN_W'(ONE / 2);
        else
            den_val = den_raw[DEN_W-1:0];
    end

    // operand select per step
    always_comb
    begin
        unique case (step_reg)
            P_CH:    begin mul_a = ext_t(c_reg);             mul_b = cut_v(h_val);  end
            P_CHE:   begin mul_a = cut_v(prod_reg[P_CH]);    mul_b = ext_t(e_reg);  end
            P_FG:    begin mul_a = ext_t(f_reg);             mul_b = ext_t(g_reg);  end
            P_CHG:   begin mul_a = cut_v(prod_reg[P_CH]);    mul_b = ext_t(g_reg);  end
            P_FE:    begin mul_a = ext_t(f_reg);             mul_b = ext_t(e_reg);  end
            P_LH:    begin mul_a = ext_t(l_reg);             mul_b = cut_v(h_val);  end
            P_CD:    begin mul_a = ext_t(c_reg);             mul_b = ext_t(d_reg);  end
            P_LD:    begin mul_a = ext_t(l_reg);             mul_b = ext_t(d_reg);  end
            P_CDG:   begin mul_a = cut_v(prod_reg[P_CD]);    mul_b = ext_t(g_reg);  end
            P_CDE:   begin mul_a = cut_v(prod_reg[P_CD]);    mul_b = ext_t(e_reg);  end
            P_LHM:   begin mul_a = cut_v(prod_reg[P_LH]);    mul_b = ext_t(m_reg);  end
            P_TN:    begin mul_a = cut_v(t_val);             mul_b = ext_t(n_reg);  end
            P_LHN:   begin mul_a = cut_v(prod_reg[P_LH]);    mul_b = ext_t(n_reg);  end
            P_TM:    begin mul_a = cut_v(t_val);             mul_b = ext_t(m_reg);  end
            P_B1:
            begin
                mul_a = cut_v(prod_reg[P_FE] - prod_reg[P_CDG]);
                mul_b = ext_t(m_reg);
            end
            P_LDN:   begin mul_a = cut_v(prod_reg[P_LD]);    mul_b = ext_t(n_reg);  end
            P_PX:
            begin
                mul_a = op_t'({1'b0, quo_reg[Q_W-1:1]});
                mul_b = cut_v(prod_reg[P_LHM] - prod_reg[P_TN]);
            end
            P_PY:
            begin
                mul_a = op_t'({1'b0, quo_reg[Q_W-1:1]});
                mul_b = cut_v(prod_reg[P_LHN] + prod_reg[P_TM]);
            end
            default: begin mul_a = '0;                        mul_b = '0;            end
        endcase
        mul_full = mul_a * mul_b;
        mul_sh   = mul_full >>> FRAC_BITS;
    end

    // final screen position, shade and cell checks
    always_comb
    begin
        val_t                sx, sy, xv, yv, lum, nl, addr_full;
        logic                on_screen;
        logic [PW-1:0]       rq;
        logic [DEPTH_W-1:0]  dep;
        sx  = X_CENTER * ONE + X_SCALE * prod_reg[P_PX];
        sy  = Y_CENTER * ONE + Y_SCALE * prod_reg[P_PY];
        xv  = sx >>> FRAC_BITS;
        yv  = sy >>> FRAC_BITS;
        on_screen = (sx >= ONE) && (xv < SCREEN_COLS) && (sy >= ONE) && (yv < SCREEN_ROWS);
        addr_full = xv + SCREEN_COLS * yv;
        lum = prod_reg[P_B1] - prod_reg[P_CDE] - prod_reg[P_FG] - prod_reg[P_LDN];
        nl  = (LUM_SCALE * lum) >>> FRAC_BITS;
        dep = (quo_reg > Q_W'(DEPTH_MAX)) ? DEPTH_W'(DEPTH_MAX) : quo_reg[DEPTH_W-1:0];
        rq  = (PW'(cell_reg) * PW'(RMUL)) >> RSH;

        work_next = '0;
        if (is_read_reg)
        begin
            work_next.is_read = 1'b1;
            work_next.hit     = (cell_reg < CELLS);
            work_next.col0    = (PW'(rq * SCREEN_COLS) == PW'(cell_reg));
            if (cell_reg < CELLS)
                work_next.addr = ADDR_W'(cell_reg);
        end
        else
        begin
            work_next.hit   = on_screen;
            work_next.depth = dep;
            if (on_screen)
                work_next.addr = addr_full[ADDR_W-1:0];
            priority if (lum < 0)
                work_next.shade = '0;
            else if (nl > SHADE_MAX)
                work_next.shade = SHADE_W'(SHADE_MAX);
            else
                work_next.shade = nl[SHADE_W-1:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            F_IDLE:
                if (accept)
                    state_next = mode ? F_FIN : F_LOOK;
            F_LOOK:
            begin
                step_next  = P_CH;
                state_next = F_MUL;
            end
            F_MUL:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == P_LDN)
                    state_next = F_DSTART;
            end
            F_DSTART:
                state_next = F_DIV;
            F_DIV:
                if (div_done)
                begin
                    step_next  = P_PX;
                    state_next = F_PROJ;
                end
            F_PROJ:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == P_PY)
                    state_next = F_FIN;
            end
            F_FIN:
                state_next = F_PUSH;
            F_PUSH:
                if (!q_full)
                    state_next = F_IDLE;
            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_read_reg <= mode;
            th_reg      <= ring_angle;
            ph_reg      <= tube_angle;
            ra_reg      <= rot_a;
            rb_reg      <= rot_b;
            cell_reg    <= cell_req;
        end
        if (state_reg == F_LOOK)
        begin
            c_reg <= trig(ph_reg);
            l_reg <= trig(ph_reg + ANGLE_BITS'(QTR_SIZE));
            f_reg <= trig(th_reg);
            d_reg <= trig(th_reg + ANGLE_BITS'(QTR_SIZE));
            e_reg <= trig(ra_reg);
            g_reg <= trig(ra_reg + ANGLE_BITS'(QTR_SIZE));
            n_reg <= trig(rb_reg);
            m_reg <= trig(rb_reg + ANGLE_BITS'(QTR_SIZE));
        end
        if ((state_reg == F_MUL) || (state_reg == F_PROJ))
            prod_reg[step_reg] <= mul_sh[VAL_W-1:0];
        if ((state_reg == F_DIV) && div_done)
            quo_reg <= div_quo;
        if (state_reg == F_FIN)
            work_reg <= work_next;
    end

    tar_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .den   (den_val),
        .done  (div_done),
        .quo   (div_quo)
    );

endmodule
`default_nettype wire

/* rtl/tar_queue.sv */
`default_nettype none
// ============================================================================
// tar_queue - two-entry work queue
// Decouples the projection front end from the store back end.
// ============================================================================
module tar_queue (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  tar_pkg::work_t  push_data,
    output logic            full,
    input  wire             pop,
    output tar_pkg::work_t  head,
    output logic            empty
);
    import tar_pkg::*;

    work_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue pop while empty");
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue level did not follow push");

endmodule
`default_nettype wire

/* rtl/tar_back.sv */
`default_nettype none
// ============================================================================
// tar_back - depth and shade stores
// Clears both stores after reset, then runs depth test and write for plot
// words and read-and-clear for read words; holds the result word.
// ============================================================================
module tar_back #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 22
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  tar_pkg::work_t                  head,
    input  wire                             empty,
    output logic                            pop,
    output logic                            clearing,
    output logic                            res_valid,
    input  wire                             res_stall,
    output logic [tar_pkg::CHAR_W-1:0]      char_code,
    output logic                            plotted
);
    import tar_pkg::*;

    localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

    typedef enum logic [3:0] {
        B_CLEAR = 4'b0001,
        B_IDLE  = 4'b0010,
        B_EXEC  = 4'b0100,
        B_OUT   = 4'b1000
    } bstate_t;

    logic [DEPTH_W-1:0] depth_mem [CELLS];
    logic [SHADE_W-1:0] shade_mem [CELLS];

    bstate_t            state_reg, state_next;
    logic [AW-1:0]      clr_cnt_reg;
    work_t              cur_reg;
    logic [DEPTH_W-1:0] rd_depth_reg;
    logic [SHADE_W-1:0] rd_shade_reg;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               plotted_reg, plotted_next;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [DEPTH_W-1:0] mem_wdepth;
    logic [SHADE_W-1:0] mem_wshade;

    assign pop       = (state_reg == B_IDLE) && !empty;
    assign clearing  = (state_reg == B_CLEAR);
    assign res_valid = (state_reg == B_OUT);
    assign char_code = char_reg;
    assign plotted   = plotted_reg;

    // store update and result
    always_comb
    begin
        state_next   = state_reg;
        mem_we       = 1'b0;
        mem_waddr    = cur_reg.addr[AW-1:0];
        mem_wdepth   = '0;
        mem_wshade   = BLANK_SHADE;
        char_next    = char_reg;
        plotted_next = plotted_reg;
        unique case (state_reg)
            B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                if (clr_cnt_reg == LAST_CELL)
                    state_next = B_IDLE;
            end
            B_IDLE:
                if (!empty)
                    state_next = B_EXEC;
            B_EXEC:
            begin
                state_next   = B_OUT;
                char_next    = CH_NONE;
                plotted_next = 1'b0;
                if (cur_reg.is_read)
                begin
                    char_next = CH_SPACE;
                    if (cur_reg.hit)
                    begin
                        mem_we = 1'b1;
                        priority if (cur_reg.col0)
                            char_next = CH_NEWLINE;
                        else if (rd_shade_reg < BLANK_SHADE)
                            char_next = SHADE_CHARS[rd_shade_reg];
                    end
                end
                else if (cur_reg.hit && (cur_reg.depth > rd_depth_reg))
                begin
                    mem_we       = 1'b1;
                    mem_wdepth   = cur_reg.depth;
                    mem_wshade   = cur_reg.shade;
                    plotted_next = 1'b1;
                end
            end
            B_OUT:
                if (!res_stall)
                    state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
        char_reg    <= char_next;
        plotted_reg <= plotted_next;
    end

    // stores: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            depth_mem[mem_waddr] <= mem_wdepth;
            shade_mem[mem_waddr] <= mem_wshade;
        end
        rd_depth_reg <= depth_mem[head.addr[AW-1:0]];
        rd_shade_reg <= shade_mem[head.addr[AW-1:0]];
    end

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && plotted) |-> (char_code == CH_NONE))
        else $error("plot result carries a character");
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (!pop && !res_valid))
        else $error("work taken during clearing pass");
    a_pop_exec: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == B_EXEC))
        else $error("popped word not executed");

endmodule
`default_nettype wire

/* rtl/torus_ascii_zbuffer_render.sv */
`default_nettype none
// Plot word from accept to result: table lookup, 16 shared 24x24 multiplies,
//   divider start and divide, 2 projection multiplies, store update.
// Read word: skips the lookup, multiplies and divide. The front end takes no new
//   item until its last word is pushed; the multiplier and divider set the plot pace.
// After reset both stores are cleared, one cell a cycle, all SCREEN_COLS*SCREEN_ROWS
//   cells (1760 by default) before the first accept.
// ============================================================================
// torus_ascii_zbuffer_render - spinning torus ASCII rasterizer, top level
// Front end projects surface points, a queue decouples it from the back end
// that holds the depth and shade stores.
// ============================================================================
module torus_ascii_zbuffer_render #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 22
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             item_valid,
    output logic                            item_stall,
    input  wire                             mode,
    input  wire  [tar_pkg::ANGLE_BITS-1:0]  ring_angle,
    input  wire  [tar_pkg::ANGLE_BITS-1:0]  tube_angle,
    input  wire  [tar_pkg::ANGLE_BITS-1:0]  rot_a,
    input  wire  [tar_pkg::ANGLE_BITS-1:0]  rot_b,
    input  wire  [tar_pkg::CELL_W-1:0]      cell_req,
    output logic                            res_valid,
    input  wire                             res_stall,
    output logic [tar_pkg::CHAR_W-1:0]      char_code,
    output logic                            plotted
);
    import tar_pkg::*;

    logic  push, q_full, pop, q_empty, clearing;
    work_t push_data, q_head;

    tar_front #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .mode       (mode),
        .ring_angle (ring_angle),
        .tube_angle (tube_angle),
        .rot_a      (rot_a),
        .rot_b      (rot_b),
        .cell_req   (cell_req),
        .clearing   (clearing),
        .push       (push),
        .push_data  (push_data),
        .q_full     (q_full)
    );

    tar_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    tar_back #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (pop),
        .clearing  (clearing),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .char_code (char_code),
        .plotted   (plotted)
    );

endmodule
`default_nettype wire
